FILE: rtl/led_breathe_dimmer_defines.svh
// Assertion macros for the dimmer checker
`ifndef LED_BREATHE_DIMMER_DEFINES_SVH
`define LED_BREATHE_DIMMER_DEFINES_SVH

`define LBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define LBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/lbd_pkg.sv
`timescale 1ns / 1ps
package lbd_pkg;
    localparam int PHASE_W = 10;
    localparam int NPH = 1 << PHASE_W;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_SOLID = 2'd1;
    localparam logic [1:0] MODE_BREATHE = 2'd2;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_RED = 3'd1;
    localparam logic [2:0] REG_GREEN = 3'd2;
    localparam logic [2:0] REG_BLUE = 3'd3;
    localparam logic [2:0] REG_PERIOD = 3'd4;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] brightness_now;
    } t_result;

    function automatic logic [63:0] cos_q30(input logic [63:0] x);
        logic [63:0] x2, term, pos, neg;
        x2 = (x * x) >> 30;
        term = 64'd1073741824;
        pos = term;
        neg = 64'd0;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) neg = neg + term;
            else pos = pos + term;
        end
        return (neg > pos) ? 64'd0 : pos - neg;
    endfunction

    // brightness for phase index idx, computed at elaboration
    function automatic logic [7:0] bright_of(input int idx);
        int j, u;
        logic neg_side;
        logic [63:0] c, x;
        j = (idx <= NPH / 2) ? idx : NPH - idx;
        neg_side = j > NPH / 4;
        u = neg_side ? (NPH / 2 - j) : j;
        x = (64'd1686629713 * 64'(u)) / 64'(NPH / 4);
        c = cos_q30(x);
        if (neg_side) return 8'((64'd255 * (64'd1073741824 + c)) >> 31);
        return 8'((64'd255 * (64'd1073741824 - c)) >> 31);
    endfunction
endpackage

FILE: rtl/lbd_if.sv
`timescale 1ns / 1ps
interface lbd_if #(parameter int W = 32);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/led_breathe_dimmer.sv
`timescale 1ns / 1ps
// channel | dir | payload
// cfg     | in  | APB write/read of mode, levels, period
// tick    | in  | now_ms
// res     | out | red_out, green_out, blue_out, brightness_now
// One tick enters per cycle while the result side is not stalled.
// The chain of divide cells, one quotient bit per cell, makes up most of the latency.
// Reset is synchronous; the pipeline advances only when the output can move.
// A stall on the result side holds all stages.
module led_breathe_dimmer #(
    parameter int PERIOD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lbd_if.sink         tick,
    lbd_if.source       res
);
    import lbd_pkg::*;
    localparam int PW = PERIOD_BITS;
    localparam int NS = 32 + PHASE_W;
    localparam int L = NS + 3;

    t_color         r_col;
    logic [PW-1:0]  r_per;
    logic [2:0]     w_idx;
    logic           w_wr;
    logic           w_adv;
    logic [L-1:0]   r_vld;
    logic [1:0]     r_mode [NS+2];
    logic [PW:0]    w_rem [NS+1];
    logic [PW-1:0]  w_div [NS+1];
    logic [PHASE_W-1:0] w_quo [NS+1];
    logic [31:0]    r_tm [31];
    logic [7:0]     r_br;
    logic [15:0]    r_pr, r_pg, r_pb;
    logic [7:0]     r_b2;
    t_result        r_res;

    assign pready = 1'b1;
    assign w_idx = paddr[4:2];
    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_per <= PW'(2000);
        end else if (w_wr) begin
            case (w_idx)
                REG_MODE:   r_col.mode <= pwdata[1:0];
                REG_RED:    r_col.red <= pwdata[7:0];
                REG_GREEN:  r_col.green <= pwdata[7:0];
                REG_BLUE:   r_col.blue <= pwdata[7:0];
                REG_PERIOD: if (pwdata[PW-1:0] != '0) r_per <= pwdata[PW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MODE:   prdata = {30'd0, r_col.mode};
            REG_RED:    prdata = {24'd0, r_col.red};
            REG_GREEN:  prdata = {24'd0, r_col.green};
            REG_BLUE:   prdata = {24'd0, r_col.blue};
            REG_PERIOD: prdata = 32'(r_per);
            default:    prdata = '0;
        endcase
    end

    assign w_adv = !res.valid || res.ready;
    assign tick.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_adv) r_vld <= {r_vld[L-2:0], tick.valid};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mode[0] <= r_col.mode;
            r_tm[0] <= tick.data;
            for (int i = 1; i < NS + 2; i++) r_mode[i] <= r_mode[i-1];
            for (int i = 1; i < 31; i++) r_tm[i] <= r_tm[i-1];
        end
    end

    assign w_rem[0] = '0;
    assign w_div[0] = r_per;
    assign w_quo[0] = '0;

    // first 32 cells reduce now_ms mod period, the rest give phase bits
    for (genvar g = 0; g < NS; g++) begin : g_cell
        logic w_b;
        if (g == 0) begin : g_in
            assign w_b = tick.data[31];
        end else if (g < 32) begin : g_mid
            assign w_b = r_tm[g-1][31-g];
        end else begin : g_fr
            assign w_b = 1'b0;
        end
        lbd_cell #(.PW(PW), .QW(PHASE_W)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_rem (w_rem[g]),
            .i_div (w_div[g]),
            .i_quo (w_quo[g]),
            .i_bit (w_b),
            .o_rem (w_rem[g+1]),
            .o_div (w_div[g+1]),
            .o_quo (w_quo[g+1])
        );
    end

    logic [7:0] w_lut [NPH];
    for (genvar k = 0; k < NPH; k++) begin : g_lut
        assign w_lut[k] = bright_of(k);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_br <= w_lut[w_quo[NS]];
            r_pr <= r_col.red * r_br;
            r_pg <= r_col.green * r_br;
            r_pb <= r_col.blue * r_br;
            r_b2 <= r_br;
            case (r_mode[NS+1])
                MODE_SOLID: r_res <= {r_col.red, r_col.green, r_col.blue, 8'd255};
                MODE_BREATHE: r_res <= {r_pr[15:8], r_pg[15:8], r_pb[15:8], r_b2};
                default: r_res <= '0;
            endcase
        end
    end

    assign res.valid = r_vld[L-1];
    assign res.data = r_res;
endmodule

FILE: rtl/lbd_cell.sv
`timescale 1ns / 1ps
// one restoring step: remainder digit and one quotient bit
module lbd_cell #(
    parameter int PW = 16,
    parameter int QW = 10
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [PW:0]   i_rem,
    input  logic [PW-1:0] i_div,
    input  logic [QW-1:0] i_quo,
    input  logic          i_bit,
    output logic [PW:0]   o_rem,
    output logic [PW-1:0] o_div,
    output logic [QW-1:0] o_quo
);
    logic [PW+1:0] w_sh;
    logic [PW+1:0] w_df;
    logic          w_ge;

    assign w_sh = {i_rem, i_bit};
    assign w_df = w_sh - {2'b00, i_div};
    assign w_ge = w_sh >= {2'b00, i_div};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= w_ge ? w_df[PW:0] : w_sh[PW:0];
            o_div <= i_div;
            o_quo <= {i_quo[QW-2:0], w_ge};
        end
    end
endmodule

FILE: rtl/lbd_checker.sv
`timescale 1ns / 1ps
`include "led_breathe_dimmer_defines.svh"
module lbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);
    `LBD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                     i_out_valid && $stable(i_out_data))
    `LBD_ASSERT_IMPL(a_rdy, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `LBD_ASSERT_IMPL(a_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)
endmodule

bind led_breathe_dimmer lbd_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (tick.ready),
    .i_out_valid (res.valid),
    .i_out_ready (res.ready),
    .i_out_data  (res.data)
);
